FILE: sv/scc_pkg.sv
// Shared types and constants for the strongly connected components core.
// No dependencies.
`timescale 1ns / 1ps
package scc_pkg;
  localparam int NodeW = 5;
  localparam int RowW  = 32;

  typedef enum logic [0:0] {
    REQ_ROW = 1'b0,
    REQ_RUN = 1'b1
  } req_t;

  // controller to datapath
  typedef struct packed {
    logic clear;     // start of run: reset pointers and flags
    logic try_root;  // examine current root
    logic scan;      // examine top frame, one column
    logic pop;       // pop one component member
    logic finish;    // leave frame after component check
  } scc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic roots_done;
    logic frames_empty;
    logic frame_done;  // top frame has no columns left
    logic descend;     // current column opens a new frame
    logic need_pop;
    logic pop_last;
  } scc_sts_t;
endpackage

FILE: sv/strongly_connected_components_core.sv
// Top level of the strongly connected components core.
// Depends on scc_pkg, scc_ctrl, scc_datapath.
`timescale 1ns / 1ps
// Row items (tuser 0) store one adjacency row, and a new row item can follow at
// once. A run item (tuser 1) performs a depth-first component search over
// node_count nodes; the sequencer scans each visited node's row a single column
// per scan step, and for each node also fetches the row, checks the end of the
// row, exits the frame and fetches the parent's row, pops the members and tries
// the roots. A run takes longer while the receiver stalls.
// No item is accepted during a run or until its last
// member has been sent. Members stream out as they complete, tlast marks the
// end of the run. The newest member waits in a holding register until the next
// member or the end of the run decides its tlast; the sequencer stalls on a pop
// while the output register is full.
module strongly_connected_components_core import scc_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,      // node_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row_index[4:0], row_bits[36:5], zero fill
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // member_node[4:0], component_number[9:5],
                                      // component_end[10], zero fill
  output logic        m_axis_tlast    // run_end
);
  logic [5:0]       node_count;
  scc_cmd_t         cmd;
  scc_sts_t         sts;
  logic             busy, emit, acc, have, out_free, send, pop_end;
  logic [NodeW-1:0] pop_node, pop_comp;
  logic [10:0]      pend;

  assign s_axis_tready = !busy && !have;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign send = have && (emit || (!busy && out_free));

  always_ff @(posedge clk) begin
    if (rst) node_count <= 6'd32;
    else if (cfg_we) node_count <= cfg_wdata;
  end

  scc_ctrl u_ctrl (
    .clk, .rst, .start(acc && s_axis_tuser == REQ_RUN), .sts, .out_free,
    .cmd, .busy, .emit
  );

  scc_datapath #(.MaxNodes(MAX_NODES)) u_dp (
    .clk, .rst,
    .row_we(acc && s_axis_tuser == REQ_ROW),
    .row_addr(s_axis_tdata[4:0]), .row_data(s_axis_tdata[36:5]),
    .node_count, .cmd, .sts, .pop_node, .pop_comp, .pop_end
  );

  // hold the newest member until the next one or run end decides tlast
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0; m_axis_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        have <= 1'b1;
        pend <= {pop_end, pop_comp, pop_node};
      end else if (send) begin
        have <= 1'b0;
      end
      if (send) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {5'd0, pend};
        m_axis_tlast <= !busy;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) emit |-> out_free)
    else $error("emit while output full");
  assert property (@(posedge clk) disable iff (rst) busy |-> !s_axis_tready)
    else $error("input ready during run");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule

FILE: sv/scc_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module scc_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/scc_datapath.sv
// Search datapath: adjacency RAM, node tables, component stack and frame stack.
// Depends on scc_pkg and scc_ram.
`timescale 1ns / 1ps
module scc_datapath import scc_pkg::*; #(
  parameter int MaxNodes = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              row_we,
  input  logic [NodeW-1:0]  row_addr,
  input  logic [RowW-1:0]   row_data,
  input  logic [5:0]        node_count,
  input  scc_cmd_t          cmd,
  output scc_sts_t          sts,
  output logic [NodeW-1:0]  pop_node,
  output logic [NodeW-1:0]  pop_comp,
  output logic              pop_end
);
  localparam int N  = (MaxNodes < RowW) ? MaxNodes : RowW;
  localparam int CW = $clog2(N + 1);
  localparam int AW = $clog2(N);

  logic [RowW-1:0]  row;
  logic [N-1:0]     visited, on_stack;
  logic [NodeW-1:0] disc [N];
  logic [NodeW-1:0] low  [N];
  logic [NodeW-1:0] cstack [N];
  logic [NodeW-1:0] fnode [N];
  logic [CW-1:0]    fcol [N];
  logic [CW-1:0]    csp, fsp, root, lim;
  logic [5:0]       dcnt;
  logic [NodeW-1:0] comp;

  logic [NodeW-1:0] v, c, w, par;
  logic [CW-1:0]    col;
  logic             edge_hit, col_end;

  // row of the top frame's node, registered, so valid in the cycle after the top frame changes
  scc_ram #(.Width(RowW), .Depth(N)) u_adj (
    .clk,
    .we(row_we && (32'(row_addr) < N)),
    .waddr(AW'(row_addr)),
    .wdata(row_data),
    .raddr(AW'(v)),
    .rdata(row)
  );

  always_comb begin
    lim = (node_count > 6'(N)) ? CW'(N) : CW'(node_count);
    v   = fnode[NodeW'(fsp - 1'b1)];
    col = fcol[NodeW'(fsp - 1'b1)];
    c   = NodeW'(col);
    col_end  = (col >= lim);
    edge_hit = !col_end && row[c];
    w   = cstack[NodeW'(csp - 1'b1)];
    par = fnode[NodeW'(fsp - 2'd2)];
    sts.roots_done   = (root >= lim);
    sts.frames_empty = (fsp == '0);
    sts.frame_done   = col_end;
    sts.descend      = edge_hit && !visited[c];
    sts.need_pop     = col_end && (low[v] == disc[v]);
    sts.pop_last     = (w == v) || (csp == CW'(1));
  end
  assign pop_node = w;
  assign pop_comp = comp;
  assign pop_end  = (w == v);

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0; on_stack <= '0; csp <= '0; fsp <= '0;
      root <= '0; dcnt <= '0; comp <= '0;
    end else if (cmd.clear) begin
      visited <= '0; on_stack <= '0; csp <= '0; fsp <= '0;
      root <= '0; dcnt <= '0; comp <= '0;
    end else if (cmd.try_root) begin
      root <= root + 1'b1;
      if (!visited[NodeW'(root)]) begin
        visited[NodeW'(root)] <= 1'b1;
        on_stack[NodeW'(root)] <= 1'b1;
        disc[NodeW'(root)] <= dcnt[NodeW-1:0];
        low[NodeW'(root)] <= dcnt[NodeW-1:0];
        dcnt <= dcnt + 1'b1;
        cstack[NodeW'(csp)] <= NodeW'(root);
        csp <= csp + 1'b1;
        fnode[NodeW'(fsp)] <= NodeW'(root);
        fcol[NodeW'(fsp)] <= '0;
        fsp <= fsp + 1'b1;
      end
    end else if (cmd.scan) begin
      if (!col_end) fcol[NodeW'(fsp - 1'b1)] <= col + 1'b1;
      if (edge_hit) begin
        if (!visited[c]) begin
          visited[c] <= 1'b1;
          on_stack[c] <= 1'b1;
          disc[c] <= dcnt[NodeW-1:0];
          low[c] <= dcnt[NodeW-1:0];
          dcnt <= dcnt + 1'b1;
          cstack[NodeW'(csp)] <= c;
          csp <= csp + 1'b1;
          fnode[NodeW'(fsp)] <= c;
          fcol[NodeW'(fsp)] <= '0;
          fsp <= fsp + 1'b1;
        end else if (on_stack[c] && disc[c] < low[v]) begin
          low[v] <= disc[c];
        end
      end
    end else if (cmd.pop) begin
      on_stack[w] <= 1'b0;
      csp <= csp - 1'b1;
      if (sts.pop_last) comp <= comp + 1'b1;
    end else if (cmd.finish) begin
      fsp <= fsp - 1'b1;
      if (fsp > CW'(1) && low[v] < low[par]) low[par] <= low[v];
    end
  end
endmodule

FILE: sv/scc_ctrl.sv
// Search sequencer and output handshake for the components core.
// Depends on scc_pkg.
`timescale 1ns / 1ps
module scc_ctrl import scc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  scc_sts_t sts,
  input  logic     out_free,
  output scc_cmd_t cmd,
  output logic     busy,
  output logic     emit
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROOT = 6'b000010,
    S_LOAD = 6'b000100,
    S_SCAN = 6'b001000,
    S_POP  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;
  state_t state, state_next;

  always_comb begin
    cmd = '0;
    emit = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: if (start) begin cmd.clear = 1'b1; state_next = S_ROOT; end
      S_ROOT: begin
        if (sts.roots_done) state_next = S_IDLE;
        else begin cmd.try_root = 1'b1; state_next = S_LOAD; end
      end
      // wait for the adjacency row of the new top frame
      S_LOAD: state_next = S_SCAN;
      S_SCAN: begin
        if (sts.frames_empty) state_next = S_ROOT;
        else if (sts.frame_done) state_next = sts.need_pop ? S_POP : S_FIN;
        else begin
          cmd.scan = 1'b1;
          if (sts.descend) state_next = S_LOAD;
        end
      end
      S_POP: if (out_free) begin
        cmd.pop = 1'b1; emit = 1'b1;
        if (sts.pop_last) state_next = S_FIN;
      end
      S_FIN: begin cmd.finish = 1'b1; state_next = S_LOAD; end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
